>>> rtl/tbgc_pkg.sv
// ----------------------------------------------------------------------------
// tbgc_pkg
// Shared widths, register indexes and item types of the two-button gesture
// classifier.
// ----------------------------------------------------------------------------
package tbgc_pkg;

   localparam int NOW_W       = 32;
   localparam int HOLD_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHORD_HOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 2'd1;

   localparam logic [HOLD_W-1:0] CHORD_HOLD_RESET = 16'd3000;
   localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd2000;

   typedef struct packed {
      logic [HOLD_W-1:0] chord_hold_ms;
      logic [HOLD_W-1:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic             update_busy;
      logic             setup_mode_active;
      logic             button_b_down;
      logic             button_a_down;
      logic [NOW_W-1:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic logging_toggle;
      logic page_following;
      logic page_previous;
      logic leave_setup;
      logic enter_setup;
      logic power_off_ignored;
      logic power_off_request;
   } event_type;

endpackage

>>> rtl/tbgc_csr.sv
// ----------------------------------------------------------------------------
// tbgc_csr
// Configuration registers: chord hold time and long press time.
// ----------------------------------------------------------------------------
module tbgc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbgc_pkg::HOLD_W-1:0]         csr_data,
   output tbgc_pkg::cfg_type                   cfg
);

   tbgc_pkg::cfg_type cfg_ff;
   tbgc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tbgc_pkg::CSR_CHORD_HOLD: cfg_in.chord_hold_ms = csr_data;
            tbgc_pkg::CSR_LONG_PRESS: cfg_in.long_press_ms = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chord_hold_ms <= tbgc_pkg::CHORD_HOLD_RESET;
         cfg_ff.long_press_ms <= tbgc_pkg::LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tbgc_core.sv
// ----------------------------------------------------------------------------
// tbgc_core
// Gesture state and classification of one poll sample into event flags.
// ----------------------------------------------------------------------------
module tbgc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  tbgc_pkg::sample_type    sample,
   input  tbgc_pkg::cfg_type       cfg,
   output tbgc_pkg::event_type     events
);

   logic                       prev_a_ff, prev_a_in;
   logic                       prev_b_ff, prev_b_in;
   logic [tbgc_pkg::NOW_W-1:0] press_a_ff, press_a_in;
   logic [tbgc_pkg::NOW_W-1:0] press_b_ff, press_b_in;
   logic [tbgc_pkg::NOW_W-1:0] chord_start_ff, chord_start_in;
   logic                       chord_armed_ff, chord_armed_in;
   logic                       long_a_ff, long_a_in;
   logic                       long_b_ff, long_b_in;
   logic                       chord_fired_ff, chord_fired_in;

   logic                       a, b, both, arm_now, fired_c, chord_hit;
   logic                       rise_a, rise_b, la2, lb2, long_a, long_b;
   logic [tbgc_pkg::NOW_W-1:0] chord_dt, a_dt, b_dt, chord_lim, long_lim;

   always_comb begin
      a         = sample.button_a_down;
      b         = sample.button_b_down;
      both      = a & b;
      chord_lim = {{(tbgc_pkg::NOW_W-tbgc_pkg::HOLD_W){1'b0}}, cfg.chord_hold_ms};
      long_lim  = {{(tbgc_pkg::NOW_W-tbgc_pkg::HOLD_W){1'b0}}, cfg.long_press_ms};

      arm_now        = both & ~chord_armed_ff;
      chord_armed_in = both;
      chord_start_in = arm_now ? sample.now_ms : chord_start_ff;
      fired_c        = arm_now ? 1'b0 : chord_fired_ff;
      chord_dt       = sample.now_ms - chord_start_in;
      chord_hit      = both & ~fired_c & (chord_dt >= chord_lim);
      chord_fired_in = fired_c | chord_hit;

      rise_a     = a & ~prev_a_ff;
      rise_b     = b & ~prev_b_ff;
      press_a_in = rise_a ? sample.now_ms : press_a_ff;
      press_b_in = rise_b ? sample.now_ms : press_b_ff;
      la2        = rise_a ? 1'b0 : (long_a_ff | chord_hit);
      lb2        = rise_b ? 1'b0 : (long_b_ff | chord_hit);

      a_dt   = sample.now_ms - press_a_in;
      b_dt   = sample.now_ms - press_b_in;
      long_a = a & ~b & ~la2 & (a_dt >= long_lim);
      long_b = b & ~a & ~lb2 & ~sample.setup_mode_active & (b_dt >= long_lim);

      long_a_in = la2 | long_a;
      long_b_in = lb2 | long_b;
      prev_a_in = a;
      prev_b_in = b;

      events.power_off_request = chord_hit & ~sample.update_busy;
      events.power_off_ignored = chord_hit & sample.update_busy;
      events.enter_setup       = long_a & ~sample.setup_mode_active;
      events.leave_setup       = long_a & sample.setup_mode_active;
      events.page_previous     = long_b;
      events.logging_toggle    = ~a & prev_a_ff & ~long_a_in & ~sample.setup_mode_active;
      events.page_following    = ~b & prev_b_ff & ~long_b_in & ~sample.setup_mode_active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff      <= 1'b0;
         prev_b_ff      <= 1'b0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         chord_start_ff <= '0;
         chord_armed_ff <= 1'b0;
         long_a_ff      <= 1'b0;
         long_b_ff      <= 1'b0;
         chord_fired_ff <= 1'b0;
      end else if (advance) begin
         prev_a_ff      <= prev_a_in;
         prev_b_ff      <= prev_b_in;
         press_a_ff     <= press_a_in;
         press_b_ff     <= press_b_in;
         chord_start_ff <= chord_start_in;
         chord_armed_ff <= chord_armed_in;
         long_a_ff      <= long_a_in;
         long_b_ff      <= long_b_in;
         chord_fired_ff <= chord_fired_in;
      end
   end

endmodule

>>> rtl/two_button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// two_button_gesture_classifier
// Classifies two-button poll samples into chord, long press and short
// release events.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata[39:0]  one poll sample
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[7:0]   one event item
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle while the result is not stalled; each sample goes through
// an input register and a result register around one pass of logic.
// Gesture state advances as a sample moves into the result register.
// Synchronous reset clears state and restores the default hold times.
// A stalled result holds; the input register takes one more item behind it,
// then the input stalls.
// ----------------------------------------------------------------------------
module two_button_gesture_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], button_a_down[32], button_b_down[33],
   // setup_mode_active[34], update_busy[35], zero pad[39:36]
   input  logic [tbgc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // power_off_request[0], power_off_ignored[1], enter_setup[2],
   // leave_setup[3], page_previous[4], page_following[5],
   // logging_toggle[6], zero pad[7]
   output logic [tbgc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbgc_pkg::HOLD_W-1:0]         csr_data
);

   localparam int SAMPLE_W = $bits(tbgc_pkg::sample_type);
   localparam int EVENT_W  = $bits(tbgc_pkg::event_type);

   tbgc_pkg::cfg_type    cfg;
   tbgc_pkg::sample_type s1_data_ff, s1_data_in;
   tbgc_pkg::event_type  s2_data_ff, events;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s1_adv, req_take;

   tbgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .sample  (s1_data_ff),
      .cfg     (cfg),
      .events  (events)
   );

   always_comb begin
      s1_adv      = s1_valid_ff & (~s2_valid_ff | rsp_tready);
      req_tready  = ~s1_valid_ff | s1_adv;
      req_take    = req_tvalid & req_tready;
      s1_data_in  = tbgc_pkg::sample_type'(req_tdata[SAMPLE_W-1:0]);
      s1_valid_in = req_take | (s1_valid_ff & ~s1_adv);
      s2_valid_in = s1_adv | (s2_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= s1_data_in;
      end
      if (s1_adv) begin
         s2_data_ff <= events;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{(tbgc_pkg::RSP_DATA_W-EVENT_W){1'b0}}, s2_data_ff};

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-button gesture classifier. Poll samples go
// in as taps, long presses, chords and noise at several hold-time settings;
// a scoreboard predicts the event flags of every sample and checks each
// event item in order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tbgc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 200;

   class gesture_scoreboard;
      logic [HOLD_W-1:0] chord_hold;
      logic [HOLD_W-1:0] long_press;
      logic              last_a;
      logic              last_b;
      logic [NOW_W-1:0]  pressed_at_a;
      logic [NOW_W-1:0]  pressed_at_b;
      logic [NOW_W-1:0]  chord_since;
      logic              chord_armed;
      logic              a_used;
      logic              b_used;
      logic              chord_used;
      event_type         event_q[$];
      int unsigned       errors;
      int unsigned       samples;
      int unsigned       checked;
      int unsigned       hits[7];

      function new();
         chord_hold   = CHORD_HOLD_RESET;
         long_press   = LONG_PRESS_RESET;
         last_a       = 1'b0;
         last_b       = 1'b0;
         pressed_at_a = '0;
         pressed_at_b = '0;
         chord_since  = '0;
         chord_armed  = 1'b0;
         a_used       = 1'b0;
         b_used       = 1'b0;
         chord_used   = 1'b0;
         errors       = 0;
         samples      = 0;
         checked      = 0;
         foreach (hits[i]) hits[i] = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [HOLD_W-1:0] value);
         if (idx == CSR_CHORD_HOLD) chord_hold = value;
         else if (idx == CSR_LONG_PRESS) long_press = value;
      endfunction

      function void note_sample(sample_type s);
         event_type        ev;
         logic             a;
         logic             b;
         logic [NOW_W-1:0] now;
         logic [NOW_W-1:0] elapsed;
         ev  = '0;
         now = s.now_ms;
         a   = s.button_a_down;
         b   = s.button_b_down;
         if (a && b) begin
            if (!chord_armed) begin
               chord_armed = 1'b1;
               chord_since = now;
               chord_used  = 1'b0;
            end
            elapsed = now - chord_since;
            if (!chord_used && elapsed >= {16'd0, chord_hold}) begin
               chord_used = 1'b1;
               a_used     = 1'b1;
               b_used     = 1'b1;
               if (s.update_busy) ev.power_off_ignored = 1'b1;
               else ev.power_off_request = 1'b1;
            end
         end else begin
            chord_armed = 1'b0;
         end
         if (a && !last_a) begin
            pressed_at_a = now;
            a_used       = 1'b0;
         end
         if (b && !last_b) begin
            pressed_at_b = now;
            b_used       = 1'b0;
         end
         elapsed = now - pressed_at_a;
         if (a && !b && !a_used && elapsed >= {16'd0, long_press}) begin
            a_used = 1'b1;
            if (s.setup_mode_active) ev.leave_setup = 1'b1;
            else ev.enter_setup = 1'b1;
         end
         elapsed = now - pressed_at_b;
         if (b && !a && !b_used && !s.setup_mode_active &&
             elapsed >= {16'd0, long_press}) begin
            b_used           = 1'b1;
            ev.page_previous = 1'b1;
         end
         if (!a && last_a && !a_used && !s.setup_mode_active) ev.logging_toggle = 1'b1;
         if (!b && last_b && !b_used && !s.setup_mode_active) ev.page_following = 1'b1;
         last_a = a;
         last_b = b;
         for (int i = 0; i < 7; i++) if (ev[i]) hits[i]++;
         samples++;
         event_q.push_back(ev);
      endfunction

      function void match_flag(string name, logic want, logic got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0b, got %0b", name, want, got);
         end
      endfunction

      function void check_event(event_type got);
         event_type want;
         if (event_q.size() == 0) begin
            errors++;
            $error("event item with nothing pending: %b", got);
            return;
         end
         want = event_q.pop_front();
         checked++;
         match_flag("power_off_request", want.power_off_request, got.power_off_request);
         match_flag("power_off_ignored", want.power_off_ignored, got.power_off_ignored);
         match_flag("enter_setup", want.enter_setup, got.enter_setup);
         match_flag("leave_setup", want.leave_setup, got.leave_setup);
         match_flag("page_previous", want.page_previous, got.page_previous);
         match_flag("page_following", want.page_following, got.page_following);
         match_flag("logging_toggle", want.logging_toggle, got.logging_toggle);
      endfunction

      function int pending();
         return event_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [HOLD_W-1:0]      csr_data;

   gesture_scoreboard sb;
   int unsigned       burst_left;
   int unsigned       sent;
   int unsigned       stall_cycles;
   int unsigned       rx_mode;
   int unsigned       rx_left;
   int unsigned       rx_phase;
   int unsigned       cur_chord;
   int unsigned       cur_long;
   logic [NOW_W-1:0]  clock_ms;

   two_button_gesture_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_event(event_type'(rsp_tdata[6:0]));
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_sample(sample_type'(req_tdata[35:0]));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase = (rx_phase + 1) % 5;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_phase < 3);
      endcase
   end

   task automatic send_sample(logic [NOW_W-1:0] t, bit a, bit b, bit setup, bit busy);
      sample_type  s;
      int unsigned gap;
      s.now_ms            = t;
      s.button_a_down     = a;
      s.button_b_down     = b;
      s.setup_mode_active = setup;
      s.update_busy       = busy;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tdata  <= {4'b0, s};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [HOLD_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // A is held over [a_on, a_off) and B over [b_on, b_off), in ms from the start
   task automatic run_gesture(int unsigned a_on, int unsigned a_off, int unsigned b_on,
                              int unsigned b_off, int unsigned span);
      int unsigned rel;
      int unsigned step_max;
      bit          setup;
      rel      = 0;
      step_max = span / 6;
      setup    = ($urandom_range(0, 3) == 0);
      while (rel <= span) begin
         if ($urandom_range(0, 15) == 0) setup = !setup;
         send_sample(clock_ms + rel, rel >= a_on && rel < a_off, rel >= b_on && rel < b_off,
                     setup, 1'($urandom_range(0, 1)));
         rel += 1 + $urandom_range(0, step_max);
      end
      send_sample(clock_ms + rel, 1'b0, 1'b0, setup, 1'($urandom_range(0, 1)));
      clock_ms += rel + $urandom_range(1, 50);
   endtask

   task automatic run_random_gesture();
      int unsigned kind;
      int unsigned d;
      int unsigned lead;
      int unsigned hold;
      int unsigned lag;
      int unsigned end1;
      int unsigned end2;
      int unsigned x;
      int unsigned y;
      int unsigned m;
      kind = $urandom_range(0, 8);
      case (kind)
         0: begin
            d = $urandom_range(0, cur_long);
            run_gesture(0, d + 1, 0, 0, d + 1);
         end
         1: begin
            d = $urandom_range(0, cur_long);
            run_gesture(0, 0, 0, d + 1, d + 1);
         end
         2: begin
            d = cur_long + $urandom_range(0, cur_long / 2 + 4);
            run_gesture(0, d + 1, 0, 0, d + 1);
         end
         3: begin
            d = cur_long + $urandom_range(0, cur_long / 2 + 4);
            run_gesture(0, 0, 0, d + 1, d + 1);
         end
         4, 5: begin
            lead = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cur_long / 2 + 1);
            hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_chord)
                                               : cur_chord + $urandom_range(0, cur_chord / 2 + 4);
            lag  = $urandom_range(0, cur_long / 2 + 1);
            end1 = lead + hold + 1;
            end2 = end1 + lag;
            if ($urandom_range(0, 1)) begin
               if ($urandom_range(0, 1)) run_gesture(0, end1, lead, end2, end2);
               else run_gesture(0, end2, lead, end1, end2);
            end else begin
               if ($urandom_range(0, 1)) run_gesture(lead, end1, 0, end2, end2);
               else run_gesture(lead, end2, 0, end1, end2);
            end
         end
         6: begin
            m = 2 * ((cur_long > cur_chord) ? cur_long : cur_chord) + 10;
            x = $urandom_range(0, m);
            y = $urandom_range(0, m);
            end1 = $urandom_range(0, m);
            end2 = $urandom_range(0, m);
            run_gesture((x < y) ? x : y, (x < y) ? y : x,
                        (end1 < end2) ? end1 : end2, (end1 < end2) ? end2 : end1, m);
         end
         default: begin
            d = $urandom_range(1, 6);
            repeat (d) begin
               if ($urandom_range(0, 2) == 0) clock_ms += $urandom;
               else clock_ms += $urandom_range(0, cur_long + cur_chord + 2);
               send_sample(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      endcase
   endtask

   task automatic run_phase(logic [HOLD_W-1:0] chord, logic [HOLD_W-1:0] long_ms);
      int unsigned target;
      int unsigned half;
      bit          paused;
      wait_idle();
      write_csr(CSR_CHORD_HOLD, chord);
      if ($urandom_range(0, 1)) write_csr(CSR_SPARE_2, HOLD_W'($urandom));
      write_csr(CSR_LONG_PRESS, long_ms);
      if ($urandom_range(0, 1)) write_csr(CSR_SPARE_3, HOLD_W'($urandom));
      csr_valid <= 1'b0;
      cur_chord = 32'(chord);
      cur_long  = 32'(long_ms);
      clock_ms  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
      target    = sent + PHASE_ITEMS;
      half      = sent + PHASE_ITEMS / 2;
      paused    = 1'b0;
      while (sent < target) begin
         run_random_gesture();
         if (!paused && sent >= half) begin
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_CHORD_HOLD;
      csr_data   = '0;
      burst_left = 0;
      sent       = 0;
      rx_left    = 0;
      rx_phase   = 0;
      rx_mode    = 0;
      clock_ms   = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      send_sample(32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'd1000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'd1500, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'd5000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'd6999, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'd7000, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'd7500, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'd10000, 1'b1, 1'b0, 1'b1, 1'b0);
      send_sample(32'd12000, 1'b1, 1'b0, 1'b1, 1'b0);
      send_sample(32'd12500, 1'b0, 1'b0, 1'b1, 1'b0);
      send_sample(32'd20000, 1'b0, 1'b1, 1'b0, 1'b0);
      send_sample(32'd20100, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'd30000, 1'b0, 1'b1, 1'b0, 1'b0);
      send_sample(32'd32000, 1'b0, 1'b1, 1'b0, 1'b0);
      send_sample(32'd32100, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'd33000, 1'b0, 1'b1, 1'b1, 1'b0);
      send_sample(32'd33100, 1'b0, 1'b0, 1'b1, 1'b0);
      send_sample(32'd40000, 1'b1, 1'b1, 1'b0, 1'b0);
      send_sample(32'd43000, 1'b1, 1'b1, 1'b0, 1'b0);
      send_sample(32'd43500, 1'b0, 1'b0, 1'b0, 1'b1);
      send_sample(32'd50000, 1'b1, 1'b1, 1'b0, 1'b1);
      send_sample(32'd53000, 1'b1, 1'b1, 1'b0, 1'b1);
      send_sample(32'd53100, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'd53200, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'hFFFF_FC00, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'h0000_03D0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);

      run_phase(16'd3000, 16'd2000);
      run_phase(16'd0, 16'd0);
      run_phase(16'hFFFF, 16'hFFFF);
      run_phase(16'd1, 16'd0);
      run_phase(16'd0, 16'd1);
      run_phase(16'd7, 16'd3);
      run_phase(16'd200, 16'd500);
      run_phase(16'hFFFF, 16'd0);
      run_phase(HOLD_W'($urandom), HOLD_W'($urandom));
      run_phase(HOLD_W'($urandom_range(0, 50)), HOLD_W'($urandom_range(0, 50)));
      wait_idle();

      $display("summary: %0d samples checked over 10 hold-time settings", sb.checked);
      $display("summary: events pwr %0d ign %0d enter %0d leave %0d prev %0d next %0d log %0d",
               sb.hits[0], sb.hits[1], sb.hits[2], sb.hits[3], sb.hits[4], sb.hits[5],
               sb.hits[6]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/tbgc_pkg.sv
rtl/tbgc_csr.sv
rtl/tbgc_core.sv
rtl/two_button_gesture_classifier.sv
sim/tb_top.sv
